### src/ptpa_pkg.sv
// ----------------------------------------------------------------------------
// ptpa_pkg
// Shared widths, control word layout and microcode ROM for the
// peak/trough parabolic amplitude unit.
// ----------------------------------------------------------------------------
package ptpa_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int S_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int AMP_W       = 24;

    // datapath widths, all signed except the divider magnitudes
    localparam int D_W    = SAMPLE_BITS + 1;        // a - b
    localparam int DEN_W  = SAMPLE_BITS + 2;        // a - 2y + b
    localparam int Q_W    = SAMPLE_BITS + 1;        // signed quotient
    localparam int FQ_W   = SAMPLE_BITS - 1;        // quotient >>> 2
    localparam int PROD_W = D_W + FQ_W;
    localparam int E_W    = PROD_W + 1;
    localparam int DIFF_W = E_W + 1;
    localparam int SAT_W  = (DIFF_W > AMP_W) ? DIFF_W : AMP_W + 1;

    localparam int DIV_STEPS = SAMPLE_BITS;
    localparam int CNT_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    localparam int PC_W = 4;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_SETUP,
        OP_DIV,
        OP_QUOT,
        OP_MUL,
        OP_ACC,
        OP_EMIT
    } op_t;

    typedef enum logic {
        EXT_PEAK,
        EXT_TROUGH
    } ext_t;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_DIV_MORE,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t             op;
        ext_t            sel;
        cond_t           cond;
        logic [PC_W-1:0] tgt;
        logic [PC_W-1:0] nxt;
    } ucode_t;

    typedef struct packed {
        logic start;
        logic step;
    } div_ctl_t;

    // program addresses
    localparam logic [PC_W-1:0] PC_IDLE     = PC_W'(0);
    localparam logic [PC_W-1:0] PC_PK_SETUP = PC_W'(1);
    localparam logic [PC_W-1:0] PC_PK_DIV   = PC_W'(2);
    localparam logic [PC_W-1:0] PC_PK_QUOT  = PC_W'(3);
    localparam logic [PC_W-1:0] PC_PK_MUL   = PC_W'(4);
    localparam logic [PC_W-1:0] PC_PK_ACC   = PC_W'(5);
    localparam logic [PC_W-1:0] PC_TR_SETUP = PC_W'(6);
    localparam logic [PC_W-1:0] PC_TR_DIV   = PC_W'(7);
    localparam logic [PC_W-1:0] PC_TR_QUOT  = PC_W'(8);
    localparam logic [PC_W-1:0] PC_TR_MUL   = PC_W'(9);
    localparam logic [PC_W-1:0] PC_TR_ACC   = PC_W'(10);
    localparam logic [PC_W-1:0] PC_EMIT     = PC_W'(11);

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        unique case (pc)
            PC_IDLE:     w = '{OP_IDLE,  EXT_PEAK,   COND_NONE,     PC_IDLE,     PC_PK_SETUP};
            PC_PK_SETUP: w = '{OP_SETUP, EXT_PEAK,   COND_NONE,     PC_IDLE,     PC_PK_DIV};
            PC_PK_DIV:   w = '{OP_DIV,   EXT_PEAK,   COND_DIV_MORE, PC_PK_DIV,   PC_PK_QUOT};
            PC_PK_QUOT:  w = '{OP_QUOT,  EXT_PEAK,   COND_NONE,     PC_IDLE,     PC_PK_MUL};
            PC_PK_MUL:   w = '{OP_MUL,   EXT_PEAK,   COND_NONE,     PC_IDLE,     PC_PK_ACC};
            PC_PK_ACC:   w = '{OP_ACC,   EXT_PEAK,   COND_NONE,     PC_IDLE,     PC_TR_SETUP};
            PC_TR_SETUP: w = '{OP_SETUP, EXT_TROUGH, COND_NONE,     PC_IDLE,     PC_TR_DIV};
            PC_TR_DIV:   w = '{OP_DIV,   EXT_TROUGH, COND_DIV_MORE, PC_TR_DIV,   PC_TR_QUOT};
            PC_TR_QUOT:  w = '{OP_QUOT,  EXT_TROUGH, COND_NONE,     PC_IDLE,     PC_TR_MUL};
            PC_TR_MUL:   w = '{OP_MUL,   EXT_TROUGH, COND_NONE,     PC_IDLE,     PC_TR_ACC};
            PC_TR_ACC:   w = '{OP_ACC,   EXT_TROUGH, COND_NONE,     PC_IDLE,     PC_EMIT};
            PC_EMIT:     w = '{OP_EMIT,  EXT_PEAK,   COND_OUT_BUSY, PC_EMIT,     PC_IDLE};
            default:     w = '{OP_IDLE,  EXT_PEAK,   COND_NONE,     PC_IDLE,     PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

### src/ptpa_div.sv
// ----------------------------------------------------------------------------
// ptpa_div
// Restoring unsigned divider, one quotient bit per step.
// ----------------------------------------------------------------------------
module ptpa_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ptpa_pkg::div_ctl_t              ctl,
    input  logic [ptpa_pkg::SAMPLE_BITS-1:0] num_mag,
    input  logic [ptpa_pkg::DEN_W-2:0]      den_mag,
    output logic [ptpa_pkg::SAMPLE_BITS-1:0] quo,
    output logic                            last
);
    import ptpa_pkg::*;

    logic [SAMPLE_BITS-1:0] quo_reg, quo_next;
    logic [DEN_W-2:0]       rem_reg, rem_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [DEN_W-1:0]       rem_sh;
    logic [DEN_W-1:0]       rem_sub;
    logic [DEN_W-1:0]       den_ext;

    assign rem_sh  = {rem_reg, quo_reg[SAMPLE_BITS-1]};
    assign den_ext = {1'b0, den_mag};
    assign rem_sub = rem_sh - den_ext;

    always_comb begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (ctl.start) begin
            quo_next = num_mag;
            rem_next = '0;
            cnt_next = '0;
        end else if (ctl.step) begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (rem_sh >= den_ext) begin
                rem_next = rem_sub[DEN_W-2:0];
                quo_next = {quo_reg[SAMPLE_BITS-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[DEN_W-2:0];
                quo_next = {quo_reg[SAMPLE_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quo  = quo_reg;
    assign last = (cnt_reg == CNT_W'(DIV_STEPS - 1));

endmodule

### src/peak_trough_parabolic_amplitude_unit.sv
// ----------------------------------------------------------------------------
// peak_trough_parabolic_amplitude_unit
// Tracks the running maximum and minimum of a sample stream with their
// neighbors and returns the parabola-interpolated peak-to-trough amplitude.
// ----------------------------------------------------------------------------
// A sample word (s_tuser = 0) is taken while the unit is idle and a new
// sample can follow every cycle. A read word (s_tuser = 1) runs a microcoded
// program that interpolates the peak and then the trough through a shared
// restoring divider, one quotient bit per cycle; the amplitude then lands in
// the output register once no earlier amplitude is still waiting on
// m_tready. s_tready is low while that program runs. The tracker is cleared
// when the amplitude is loaded.
module peak_trough_parabolic_amplitude_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ptpa_pkg::S_TDATA_W-1:0] s_tdata,   // [11:0] sample, rest pad, ignored
    input  logic                           s_tuser,   // func: 0 sample, 1 read
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ptpa_pkg::AMP_W-1:0]     m_tdata    // [23:0] amplitude
);
    import ptpa_pkg::*;

    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'((2 ** (AMP_W - 1)) - 1);
    localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

    // tracker state
    logic [SAMPLE_BITS-1:0] last_reg, pk_val_reg, pk_bef_reg, pk_aft_reg;
    logic [SAMPLE_BITS-1:0] tr_val_reg, tr_bef_reg, tr_aft_reg;
    logic                   pk_pend_reg, tr_pend_reg;

    // sequencer
    logic [PC_W-1:0] pc_reg, pc_next;
    ucode_t          uw;
    logic            cond_hit;
    logic            emit_fire;
    logic            s_accept;

    // datapath
    logic signed [D_W-1:0]    d_reg;
    logic signed [DEN_W-1:0]  den_reg;
    logic signed [FQ_W-1:0]   fq_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [E_W-1:0]    e_pk_reg;
    logic signed [E_W-1:0]    e_tr_reg;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [AMP_W-1:0]         m_tdata_reg;

    logic [SAMPLE_BITS-1:0]   sel_y, sel_a, sel_b, s_val;
    logic signed [D_W-1:0]    d_calc, d_abs_src;
    logic signed [DEN_W-1:0]  den_calc, den_abs_src;
    logic signed [Q_W-1:0]    q_mag, q_signed;
    logic signed [E_W-1:0]    e_calc;
    logic signed [SAT_W-1:0]  diff;
    logic [AMP_W-1:0]         amp_sat;

    div_ctl_t               div_ctl;
    logic [SAMPLE_BITS-1:0] div_quo;
    logic                   div_last;

    assign uw       = ucode_rom(pc_reg);
    assign s_tready = (uw.op == OP_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign s_val    = s_tdata[SAMPLE_BITS-1:0];

    always_comb begin
        unique case (uw.cond)
            COND_NONE:     cond_hit = 1'b0;
            COND_DIV_MORE: cond_hit = !div_last;
            COND_OUT_BUSY: cond_hit = m_tvalid_reg && !m_tready;
            default:       cond_hit = 1'b0;
        endcase
    end

    always_comb begin
        if (uw.op == OP_IDLE) begin
            pc_next = (s_accept && s_tuser) ? uw.nxt : pc_reg;
        end else begin
            pc_next = cond_hit ? uw.tgt : uw.nxt;
        end
    end

    assign emit_fire = (uw.op == OP_EMIT) && !cond_hit;

    // operand selection for the extreme being interpolated
    always_comb begin
        if (uw.sel == EXT_PEAK) begin
            sel_y = pk_val_reg;
            sel_a = pk_bef_reg;
            sel_b = pk_aft_reg;
        end else begin
            sel_y = tr_val_reg;
            sel_a = tr_bef_reg;
            sel_b = tr_aft_reg;
        end
    end

    assign d_calc      = D_W'(sel_a) - D_W'(sel_b);
    assign den_calc    = DEN_W'(sel_a) + DEN_W'(sel_b) - (DEN_W'(sel_y) << 1);
    assign d_abs_src   = d_calc[D_W-1] ? -d_calc : d_calc;
    assign den_abs_src = den_calc[DEN_W-1] ? -den_calc : den_calc;

    assign div_ctl.start = (uw.op == OP_SETUP);
    assign div_ctl.step  = (uw.op == OP_DIV);

    ptpa_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (div_ctl),
        .num_mag (d_abs_src[SAMPLE_BITS-1:0]),
        .den_mag (den_abs_src[DEN_W-2:0]),
        .quo     (div_quo),
        .last    (div_last)
    );

    // truncating quotient: negate on sign mismatch, zero for a zero divisor
    always_comb begin
        q_mag = Q_W'(div_quo);
        if (den_reg == '0) begin
            q_signed = '0;
        end else if (d_reg[D_W-1] ^ den_reg[DEN_W-1]) begin
            q_signed = -q_mag;
        end else begin
            q_signed = q_mag;
        end
    end

    assign e_calc = E_W'(signed'({1'b0, sel_y})) - E_W'(prod_reg);
    assign diff   = SAT_W'(e_pk_reg) - SAT_W'(e_tr_reg);

    always_comb begin
        if (diff > SAT_HI) begin
            amp_sat = SAT_HI[AMP_W-1:0];
        end else if (diff < SAT_LO) begin
            amp_sat = SAT_LO[AMP_W-1:0];
        end else begin
            amp_sat = diff[AMP_W-1:0];
        end
    end

    always_comb begin
        if (emit_fire) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= PC_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            pc_reg       <= pc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (uw.op == OP_SETUP) begin
            d_reg   <= d_calc;
            den_reg <= den_calc;
        end
        if (uw.op == OP_QUOT) begin
            fq_reg <= FQ_W'(q_signed >>> 2);
        end
        if (uw.op == OP_MUL) begin
            prod_reg <= PROD_W'(d_reg * fq_reg);
        end
        if (uw.op == OP_ACC) begin
            if (uw.sel == EXT_PEAK) begin
                e_pk_reg <= e_calc;
            end else begin
                e_tr_reg <= e_calc;
            end
        end
        if (emit_fire) begin
            m_tdata_reg <= amp_sat;
        end
    end

    // tracker: update on sample words, clear when the amplitude is loaded
    always_ff @(posedge aclk) begin
        if (!aresetn || emit_fire) begin
            last_reg    <= '0;
            pk_val_reg  <= '0;
            pk_bef_reg  <= '0;
            pk_aft_reg  <= '0;
            tr_val_reg  <= '1;
            tr_bef_reg  <= '0;
            tr_aft_reg  <= '0;
            pk_pend_reg <= 1'b0;
            tr_pend_reg <= 1'b0;
        end else if (s_accept && !s_tuser) begin
            if (s_val > pk_val_reg) begin
                pk_val_reg  <= s_val;
                pk_bef_reg  <= last_reg;
                pk_pend_reg <= 1'b1;
            end else if (pk_pend_reg) begin
                pk_aft_reg  <= s_val;
                pk_pend_reg <= 1'b0;
            end
            if (s_val < tr_val_reg) begin
                tr_val_reg  <= s_val;
                tr_bef_reg  <= last_reg;
                tr_pend_reg <= 1'b1;
            end else if (tr_pend_reg) begin
                tr_aft_reg  <= s_val;
                tr_pend_reg <= 1'b0;
            end
            last_reg <= s_val;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### tb/sv/ptpa_tb_pkg.sv
// ----------------------------------------------------------------------------
// ptpa_tb_pkg
// Word kinds shared by the amplitude unit's stimulus and its checker.
// ----------------------------------------------------------------------------
package ptpa_tb_pkg;

    typedef enum logic {
        FUNC_SAMPLE = 1'b0,
        FUNC_READ   = 1'b1
    } func_t;

endpackage

### tb/sv/ptpa_amplitude_checker.sv
// ----------------------------------------------------------------------------
// ptpa_amplitude_checker
// Watches both streams of the peak/trough amplitude unit, tracks the
// extremes and their neighbors on every accepted sample, predicts the
// interpolated amplitude on every accepted read and compares it with the
// words that leave the block, in order.
// ----------------------------------------------------------------------------
module ptpa_amplitude_checker
    import ptpa_pkg::*;
    import ptpa_tb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [11:0] sample, rest pad, ignored
    input  logic                 s_tuser,   // func: 0 sample, 1 read
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [AMP_W-1:0]     m_tdata,   // [23:0] amplitude
    output int                   errors,
    output int                   amp_due
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [SAMPLE_BITS-1:0] prev_smp;
    logic [SAMPLE_BITS-1:0] pk_val, pk_prev, pk_next;
    logic [SAMPLE_BITS-1:0] tr_val, tr_prev, tr_next;
    logic                   pk_wait, tr_wait;
    logic [AMP_W-1:0]       amp_due_q[$];

    task automatic clear_tracker();
        prev_smp = '0;
        pk_val   = '0;
        pk_prev  = '0;
        pk_next  = '0;
        tr_val   = '1;
        tr_prev  = '0;
        tr_next  = '0;
        pk_wait  = 1'b0;
        tr_wait  = 1'b0;
    endtask

    task automatic take_sample(input logic [SAMPLE_BITS-1:0] s);
        if (s > pk_val) begin
            pk_val  = s;
            pk_prev = prev_smp;
            pk_wait = 1'b1;
        end else if (pk_wait) begin
            pk_next = s;
            pk_wait = 1'b0;
        end
        if (s < tr_val) begin
            tr_val  = s;
            tr_prev = prev_smp;
            tr_wait = 1'b1;
        end else if (tr_wait) begin
            tr_next = s;
            tr_wait = 1'b0;
        end
        prev_smp = s;
    endtask

    // vertex of the parabola through (a, y, b); q >>> 2 floors on negatives
    function automatic longint parabolic_vertex(input logic [SAMPLE_BITS-1:0] y,
                                                input logic [SAMPLE_BITS-1:0] a,
                                                input logic [SAMPLE_BITS-1:0] b);
        longint d, den, q;
        d   = longint'(a) - longint'(b);
        den = longint'(a) - 2 * longint'(y) + longint'(b);
        q   = (den != 0) ? d / den : 0;
        return longint'(y) - d * (q >>> 2);
    endfunction

    function automatic logic [AMP_W-1:0] predicted_amplitude();
        longint spread, top, bottom;
        top    = (longint'(1) <<< (AMP_W - 1)) - 1;
        bottom = -(longint'(1) <<< (AMP_W - 1));
        spread = parabolic_vertex(pk_val, pk_prev, pk_next)
               - parabolic_vertex(tr_val, tr_prev, tr_next);
        if (spread > top) begin
            spread = top;
        end else if (spread < bottom) begin
            spread = bottom;
        end
        return spread[AMP_W-1:0];
    endfunction

    always @(posedge aclk) begin
        logic [AMP_W-1:0] want;
        if (!aresetn) begin
            clear_tracker();
            amp_due_q.delete();
        end else begin
            // check the outgoing word before queuing a new read
            if (m_tvalid && m_tready) begin
                if (amp_due_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("unexpected amplitude word 0x%06h at %0t", m_tdata, $realtime);
                    end
                end else begin
                    want = amp_due_q.pop_front();
                    if (m_tdata !== want) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("amplitude mismatch at %0t: expected %0d (0x%06h), got %0d (0x%06h)",
                                     $realtime, $signed(want), want, $signed(m_tdata), m_tdata);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == FUNC_READ) begin
                    amp_due_q.push_back(predicted_amplitude());
                    clear_tracker();
                end else begin
                    take_sample(s_tdata[SAMPLE_BITS-1:0]);
                end
            end
        end
        amp_due = amp_due_q.size();
    end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the peak/trough parabolic amplitude unit: a directed pass over
// the corner cases, then random sample runs closed by reads, with random
// idle gaps on the input and random back-pressure on the output.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptpa_pkg::*;
    import ptpa_tb_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [AMP_W-1:0]     m_tdata;

    int fail_total;
    int due_total;
    int words_sent;
    int reads_sent;
    bit calm_in;
    bit calm_out;

    peak_trough_parabolic_amplitude_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ptpa_amplitude_checker chk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (fail_total),
        .amp_due  (due_total)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("tb: FAIL");
        $finish;
    end

    // mostly no gap, some short ones, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_word(input func_t f, input logic [S_TDATA_W-1:0] d);
        int gap;
        gap = calm_in ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        words_sent++;
        if (f == FUNC_READ) reads_sent++;
    endtask

    task automatic put_sample(input int unsigned v);
        logic [S_TDATA_W-1:0] d;
        d = S_TDATA_W'(v);
        // now and then dirty the pad bits above the sample
        if ($urandom_range(0, 7) == 0) begin
            d[S_TDATA_W-1:SAMPLE_BITS] = (S_TDATA_W - SAMPLE_BITS)'($urandom);
        end
        send_word(FUNC_SAMPLE, d);
    endtask

    task automatic put_read();
        send_word(FUNC_READ, S_TDATA_W'($urandom));
    endtask

    // output back-pressure
    initial begin
        int hold;
        m_tready = 1'b0;
        hold = 0;
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 199) == 0) calm_out = !calm_out;
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
                if (!calm_out) hold = idle_len();
            end
        end
    end

    initial begin
        int kind, len, lvl, span, hi, lo;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = FUNC_SAMPLE;
        s_tdata  = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // read with nothing tracked, then again on a cleared tracker
        put_read();
        put_read();
        // full-scale sample through dirty pad bits, read with peak pending
        send_word(FUNC_SAMPLE, S_TDATA_W'(16'hFFFF));
        put_read();
        // zero, mid-scale with pad bits set, full scale, small value
        send_word(FUNC_SAMPLE, S_TDATA_W'(0));
        send_word(FUNC_SAMPLE, S_TDATA_W'(16'hF800));
        send_word(FUNC_SAMPLE, S_TDATA_W'(4095));
        send_word(FUNC_SAMPLE, S_TDATA_W'(100));
        put_read();
        // trough neighbors make the divisor zero
        send_word(FUNC_SAMPLE, S_TDATA_W'(2000));
        send_word(FUNC_SAMPLE, S_TDATA_W'(1000));
        put_read();
        // quotient of minus one: the shift must floor it
        send_word(FUNC_SAMPLE, S_TDATA_W'(2001));
        send_word(FUNC_SAMPLE, S_TDATA_W'(1999));
        put_read();
        // quotient of minus three
        send_word(FUNC_SAMPLE, S_TDATA_W'(3000));
        send_word(FUNC_SAMPLE, S_TDATA_W'(2000));
        put_read();
        // well-formed pulse with both neighbors known
        send_word(FUNC_SAMPLE, S_TDATA_W'(60));
        send_word(FUNC_SAMPLE, S_TDATA_W'(100));
        send_word(FUNC_SAMPLE, S_TDATA_W'(95));
        send_word(FUNC_SAMPLE, S_TDATA_W'(20));
        send_word(FUNC_SAMPLE, S_TDATA_W'(5));
        send_word(FUNC_SAMPLE, S_TDATA_W'(30));
        put_read();

        while (words_sent < 1550 || reads_sent < 40) begin
            if ($urandom_range(0, 9) == 0) calm_in = !calm_in;
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                // random walk, clamped at both rails
                len  = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(2, 9);
                lvl  = $urandom_range(0, 4095);
                span = $urandom_range(1, 600);
                repeat (len) begin
                    lvl = lvl + $urandom_range(0, 2 * span) - span;
                    if (lvl < 0) lvl = 0;
                    if (lvl > 4095) lvl = 4095;
                    put_sample(lvl);
                end
                put_read();
            end else if (kind < 65) begin
                repeat ($urandom_range(1, 12)) put_sample($urandom_range(0, 4095));
                put_read();
            end else if (kind < 85) begin
                // drop, then read with the trough neighbor still pending
                hi = $urandom_range(1, 4095);
                lo = $urandom_range(0, hi - 1);
                put_sample(hi);
                put_sample(lo);
                put_read();
            end else if (kind < 92) begin
                put_read();
            end else begin
                repeat ($urandom_range(1, 6)) put_sample($urandom_range(0, 4095));
            end
        end

        s_tvalid <= 1'b0;
        while (due_total != 0) @(negedge aclk);
        repeat (48) @(negedge aclk);
        if (fail_total == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
